FILE: design/corner_rounding_tangent_points_unit_defines.svh
// ---------------------------------------------------------------------------
// Corner rounding tangent points: assertion macros
// Overlapping-implication and next-cycle checks, compiled out by NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef CORNER_ROUNDING_TANGENT_POINTS_UNIT_DEFINES_SVH
`define CORNER_ROUNDING_TANGENT_POINTS_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CRTP_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
`define CRTP_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define CRTP_ASSERT_IMP(label, clk, rst, a, b)
`define CRTP_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

FILE: design/crtp_pkg.sv
// ---------------------------------------------------------------------------
// Corner rounding tangent points: package
// Widths, payload types and pipeline side data.
// ---------------------------------------------------------------------------
`default_nettype none
package crtp_pkg;

   localparam int COORD_W      = 24;
   localparam int FRAC_BITS    = 8;
   localparam int OFFSET_W     = 23;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(50 << FRAC_BITS);
   localparam int MAG_W        = COORD_W + 1;
   localparam int SQ_W         = 2 * COORD_W + 2;
   localparam int ROOT_W       = COORD_W + 1;
   localparam int QUO_W        = COORD_W + 1;
   localparam int LIM_W        = 2 * OFFSET_W + 2;
   localparam int PROD_W       = MAG_W + ROOT_W;
   localparam int LANES        = 4;
   localparam logic ADDR_OFFSET = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] prev_x;
      logic signed [COORD_W-1:0] prev_y;
      logic signed [COORD_W-1:0] next_x;
      logic signed [COORD_W-1:0] next_y;
      logic signed [COORD_W-1:0] corner_x;
      logic signed [COORD_W-1:0] corner_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] entry_x;
      logic signed [COORD_W-1:0] entry_y;
      logic signed [COORD_W-1:0] exit_x;
      logic signed [COORD_W-1:0] exit_y;
      logic                      shortened;
      logic                      degenerate;
   } rsp_type;

   // lanes: 0 prev x, 1 prev y, 2 next x, 3 next y
   typedef struct packed {
      logic signed [COORD_W-1:0]       corner_x;
      logic signed [COORD_W-1:0]       corner_y;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0][MAG_W-1:0]     mag;
      logic                            shortened;
      logic                            degenerate;
      logic [1:0][ROOT_W-1:0]          len;
   } side_type;

endpackage
`default_nettype wire

FILE: design/corner_rounding_tangent_points_unit.sv
// ---------------------------------------------------------------------------
// Corner rounding tangent points unit
// Leg lengths by pipelined square root, tangent points by pipelined division.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one corner (prev, corner, next points) per item; rsp_*
//   returns the entry and exit tangent points with shortened and degenerate
//   flags. An item is taken when valid is high and stall is low.
//   The pipeline has 56 register stages: three front stages (delta, square,
//   sum), 25 restoring square-root stages, one stage for the distance and
//   products, 25 restoring divider stages, a rounding stage and the output
//   register. One item is accepted every cycle while req_stall is low; the
//   bit-per-stage square root and divider set the depth.
//   The corner offset register sits at byte address 0 of the APB port; the
//   user must see that it is written only while the unit is idle, as the unit does not enforce this.
//   Reset empties the pipeline and loads the offset with 50.0.
//   While rsp_valid is high and rsp_stall is high the whole pipeline holds
//   and req_stall is raised; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none
`include "corner_rounding_tangent_points_unit_defines.svh"
module corner_rounding_tangent_points_unit
   import crtp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire req_type       req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      rsp_type       rsp_data,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [2:0]    paddr,
   input  wire logic [31:0]   pwdata,
   output      logic [31:0]   prdata,
   output      logic          pready
);

   logic                 en;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [LIM_W-1:0]     lim_ff;

   logic                 a_valid_ff;
   side_type             a_side_ff, a_side_in;
   logic                 b_valid_ff;
   side_type             b_side_ff;
   logic [1:0][SQ_W-1:0] b_sq_ff [2];

   logic                 sq_valid_ff [ROOT_W+1];
   side_type             sq_side_ff  [ROOT_W+1];
   side_type             sq_side_in;
   logic [SQ_W-1:0]      sq_rem_ff   [ROOT_W+1][2];
   logic [ROOT_W-1:0]    sq_root_ff  [ROOT_W+1][2];
   logic [SQ_W-1:0]      sq_rem_in   [ROOT_W][2];
   logic [ROOT_W-1:0]    sq_root_in  [ROOT_W][2];
   logic [SQ_W-1:0]      sq_trial    [ROOT_W][2];
   logic [1:0][SQ_W-1:0] c_sum;

   logic                 dv_valid_ff [QUO_W+1];
   side_type             dv_side_ff  [QUO_W+1];
   side_type             dv_side_in;
   logic [ROOT_W-1:0]    dv_rem_ff   [QUO_W+1][LANES];
   logic [QUO_W-1:0]     dv_lq_ff    [QUO_W+1][LANES];
   logic [ROOT_W-1:0]    dv_rem_in   [QUO_W][LANES];
   logic [QUO_W-1:0]     dv_lq_in    [QUO_W][LANES];
   logic [ROOT_W:0]      dv_shift    [QUO_W][LANES];
   logic [ROOT_W-1:0]    d_dist;
   logic [PROD_W-1:0]    d_prod      [LANES];

   logic                 e_valid_ff;
   side_type             e_side_ff;
   logic [MAG_W-1:0]     e_q_ff      [LANES];
   logic [MAG_W-1:0]     e_q_in      [LANES];
   logic [QUO_W:0]       e_round     [LANES];

   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic signed [COORD_W+1:0] f_sum  [LANES];
   logic [COORD_W-1:0]   f_res       [LANES];

   localparam logic signed [COORD_W+1:0] SAT_HI = {3'b000, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W+1:0] SAT_LO = {3'b111, {(COORD_W-1){1'b0}}};

   function automatic logic [ROOT_W-1:0] lane_len(side_type s, int k);
      return (k < 2) ? s.len[0] : s.len[1];
   endfunction

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == ADDR_OFFSET) ? {(32-OFFSET_W)'(0), offset_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_OFFSET) begin
         offset_ff <= pwdata[OFFSET_W-1:0];
      end
      lim_ff <= {(LIM_W-2)'(offset_ff * offset_ff), 2'b00};
   end

   // delta and magnitude
   always_comb begin
      logic signed [MAG_W-1:0] dlt [LANES];
      dlt[0] = {req_data.prev_x[COORD_W-1], req_data.prev_x}
             - {req_data.corner_x[COORD_W-1], req_data.corner_x};
      dlt[1] = {req_data.prev_y[COORD_W-1], req_data.prev_y}
             - {req_data.corner_y[COORD_W-1], req_data.corner_y};
      dlt[2] = {req_data.next_x[COORD_W-1], req_data.next_x}
             - {req_data.corner_x[COORD_W-1], req_data.corner_x};
      dlt[3] = {req_data.next_y[COORD_W-1], req_data.next_y}
             - {req_data.corner_y[COORD_W-1], req_data.corner_y};
      a_side_in            = '0;
      a_side_in.corner_x   = req_data.corner_x;
      a_side_in.corner_y   = req_data.corner_y;
      for (int k = 0; k < LANES; k++) begin
         a_side_in.neg[k] = dlt[k][MAG_W-1];
         a_side_in.mag[k] = dlt[k][MAG_W-1] ? MAG_W'(-dlt[k]) : MAG_W'(dlt[k]);
      end
   end

   // leg sums and checks
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         c_sum[k] = b_sq_ff[k][0] + b_sq_ff[k][1];
      end
      sq_side_in            = b_side_ff;
      sq_side_in.shortened  = (c_sum[0] <= SQ_W'(lim_ff)) ||
                              (c_sum[1] <= SQ_W'(lim_ff));
      sq_side_in.degenerate = (c_sum[0] == '0) || (c_sum[1] == '0);
   end

   // square root, one root bit per stage
   always_comb begin
      for (int j = 0; j < ROOT_W; j++) begin
         for (int k = 0; k < 2; k++) begin
            sq_trial[j][k] = (SQ_W'(sq_root_ff[j][k]) << (ROOT_W - j))
                           | (SQ_W'(1) << (2 * (ROOT_W - 1 - j)));
            if (sq_rem_ff[j][k] >= sq_trial[j][k]) begin
               sq_rem_in[j][k]  = sq_rem_ff[j][k] - sq_trial[j][k];
               sq_root_in[j][k] = sq_root_ff[j][k] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end else begin
               sq_rem_in[j][k]  = sq_rem_ff[j][k];
               sq_root_in[j][k] = sq_root_ff[j][k];
            end
         end
      end
   end

   // distance and products
   always_comb begin
      logic [ROOT_W-1:0] lmin;
      lmin = (sq_root_ff[ROOT_W][0] < sq_root_ff[ROOT_W][1]) ?
             sq_root_ff[ROOT_W][0] : sq_root_ff[ROOT_W][1];
      d_dist = sq_side_ff[ROOT_W].shortened ? (lmin >> 1) : ROOT_W'(offset_ff);
      for (int k = 0; k < LANES; k++) begin
         d_prod[k] = PROD_W'(sq_side_ff[ROOT_W].mag[k] * d_dist);
      end
      dv_side_in        = sq_side_ff[ROOT_W];
      dv_side_in.len[0] = sq_root_ff[ROOT_W][0];
      dv_side_in.len[1] = sq_root_ff[ROOT_W][1];
   end

   // division, one quotient bit per stage
   always_comb begin
      for (int j = 0; j < QUO_W; j++) begin
         for (int k = 0; k < LANES; k++) begin
            dv_shift[j][k] = {dv_rem_ff[j][k], dv_lq_ff[j][k][QUO_W-1]};
            if (dv_shift[j][k] >= {1'b0, lane_len(dv_side_ff[j], k)}) begin
               dv_rem_in[j][k] = ROOT_W'(dv_shift[j][k] - {1'b0, lane_len(dv_side_ff[j], k)});
               dv_lq_in[j][k]  = {dv_lq_ff[j][k][QUO_W-2:0], 1'b1};
            end else begin
               dv_rem_in[j][k] = dv_shift[j][k][ROOT_W-1:0];
               dv_lq_in[j][k]  = {dv_lq_ff[j][k][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // rounding and clamp
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         e_round[k] = {1'b0, dv_lq_ff[QUO_W][k]}
                    + (QUO_W+1)'({dv_rem_ff[QUO_W][k], 1'b0}
                                 >= {1'b0, lane_len(dv_side_ff[QUO_W], k)});
         e_q_in[k]  = (e_round[k] > {1'b0, dv_side_ff[QUO_W].mag[k]}) ?
                      dv_side_ff[QUO_W].mag[k] : e_round[k][MAG_W-1:0];
      end
   end

   // placement and saturation
   always_comb begin
      logic signed [COORD_W-1:0] cc;
      for (int k = 0; k < LANES; k++) begin
         cc = (k % 2 == 0) ? e_side_ff.corner_x : e_side_ff.corner_y;
         if (e_side_ff.neg[k]) begin
            f_sum[k] = {{2{cc[COORD_W-1]}}, cc} - $signed({1'b0, e_q_ff[k]});
         end else begin
            f_sum[k] = {{2{cc[COORD_W-1]}}, cc} + $signed({1'b0, e_q_ff[k]});
         end
         if (e_side_ff.degenerate) begin
            f_res[k] = cc;
         end else if (f_sum[k] > SAT_HI) begin
            f_res[k] = SAT_HI[COORD_W-1:0];
         end else if (f_sum[k] < SAT_LO) begin
            f_res[k] = SAT_LO[COORD_W-1:0];
         end else begin
            f_res[k] = f_sum[k][COORD_W-1:0];
         end
      end
      rsp_data_in.entry_x    = f_res[0];
      rsp_data_in.entry_y    = f_res[1];
      rsp_data_in.exit_x     = f_res[2];
      rsp_data_in.exit_y     = f_res[3];
      rsp_data_in.shortened  = e_side_ff.shortened && !e_side_ff.degenerate;
      rsp_data_in.degenerate = e_side_ff.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j <= ROOT_W; j++) sq_valid_ff[j] <= 1'b0;
         for (int j = 0; j <= QUO_W; j++) dv_valid_ff[j] <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= req_valid;
         b_valid_ff   <= a_valid_ff;
         sq_valid_ff[0] <= b_valid_ff;
         for (int j = 0; j < ROOT_W; j++) sq_valid_ff[j+1] <= sq_valid_ff[j];
         dv_valid_ff[0] <= sq_valid_ff[ROOT_W];
         for (int j = 0; j < QUO_W; j++) dv_valid_ff[j+1] <= dv_valid_ff[j];
         e_valid_ff   <= dv_valid_ff[QUO_W];
         rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         b_side_ff <= a_side_ff;
         for (int k = 0; k < 2; k++) begin
            for (int m = 0; m < 2; m++) begin
               b_sq_ff[k][m] <= SQ_W'(a_side_ff.mag[2*k+m] * a_side_ff.mag[2*k+m]);
            end
         end
         sq_side_ff[0] <= sq_side_in;
         for (int k = 0; k < 2; k++) begin
            sq_rem_ff[0][k]  <= c_sum[k];
            sq_root_ff[0][k] <= '0;
         end
         for (int j = 0; j < ROOT_W; j++) begin
            sq_side_ff[j+1] <= sq_side_ff[j];
            for (int k = 0; k < 2; k++) begin
               sq_rem_ff[j+1][k]  <= sq_rem_in[j][k];
               sq_root_ff[j+1][k] <= sq_root_in[j][k];
            end
         end
         dv_side_ff[0] <= dv_side_in;
         for (int k = 0; k < LANES; k++) begin
            dv_rem_ff[0][k] <= d_prod[k][PROD_W-1 -: ROOT_W];
            dv_lq_ff[0][k]  <= d_prod[k][QUO_W-1:0];
         end
         for (int j = 0; j < QUO_W; j++) begin
            dv_side_ff[j+1] <= dv_side_ff[j];
            for (int k = 0; k < LANES; k++) begin
               dv_rem_ff[j+1][k] <= dv_rem_in[j][k];
               dv_lq_ff[j+1][k]  <= dv_lq_in[j][k];
            end
         end
         e_side_ff <= dv_side_ff[QUO_W];
         for (int k = 0; k < LANES; k++) e_q_ff[k] <= e_q_in[k];
         rsp_data_ff <= rsp_data_in;
      end
   end

   `CRTP_ASSERT_IMP(stall_holds_input, clock, reset, rsp_valid && rsp_stall, req_stall)
   `CRTP_ASSERT_NXT(front_moves, clock, reset, en && a_valid_ff, b_valid_ff)
   `CRTP_ASSERT_IMP(div_rem_below_len, clock, reset,
                    dv_valid_ff[QUO_W] && !dv_side_ff[QUO_W].degenerate,
                    dv_rem_ff[QUO_W][0] < dv_side_ff[QUO_W].len[0])
   `CRTP_ASSERT_IMP(flags_exclusive, clock, reset, rsp_valid_ff && rsp_data_ff.degenerate,
                    !rsp_data_ff.shortened)

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// Corner rounding tangent points unit: testbench
// Streams corners through the unit under random valid/stall gaps, predicts
// each pair of tangent points with an exact integer model and checks every
// result field in order, across several corner offset settings.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
   import crtp_pkg::*;

   localparam logic [2:0] OFFSET_ADDR = 3'd0;
   localparam logic [2:0] UNUSED_ADDR = 3'd4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 70;
   localparam int HOLD_CYCLES = 300;
   localparam longint COORD_MAX = 8388607;
   localparam longint COORD_MIN = -8388608;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   corner_rounding_tangent_points_unit dut (.*);

   always #5 clock = ~clock;

   req_type pending_corners[$];
   rsp_type expected_points[$];
   logic [OFFSET_W-1:0] offset_model = OFFSET_RESET;
   int errors = 0;
   int corners_sent = 0;
   int points_checked = 0;
   int shortened_seen = 0;
   int degenerate_seen = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, c;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (c * c <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] tangent_coord(longint corner, longint delta,
                                                        longint unsigned d,
                                                        longint unsigned len);
      longint unsigned mag, prod, q, rem;
      longint r;
      mag = delta < 0 ? -delta : delta;
      prod = mag * d;
      q = prod / len;
      rem = prod % len;
      if (rem >= len - rem) q++;
      if (q > mag) q = mag;
      r = delta < 0 ? corner - longint'(q) : corner + longint'(q);
      if (r > COORD_MAX) r = COORD_MAX;
      if (r < COORD_MIN) r = COORD_MIN;
      return r[COORD_W-1:0];
   endfunction

   function automatic rsp_type predict_tangents(req_type c, logic [OFFSET_W-1:0] off);
      rsp_type p;
      longint cx, cy, dpx, dpy, dnx, dny;
      longint unsigned sq_in, sq_out, lim, len_in, len_out, d;
      cx = c.corner_x;
      cy = c.corner_y;
      dpx = longint'(c.prev_x) - cx;
      dpy = longint'(c.prev_y) - cy;
      dnx = longint'(c.next_x) - cx;
      dny = longint'(c.next_y) - cy;
      sq_in = dpx * dpx + dpy * dpy;
      sq_out = dnx * dnx + dny * dny;
      lim = 4 * longint'(off) * longint'(off);
      p = '0;
      if (sq_in == 0 || sq_out == 0) begin
         p.entry_x = c.corner_x;
         p.entry_y = c.corner_y;
         p.exit_x = c.corner_x;
         p.exit_y = c.corner_y;
         p.degenerate = 1'b1;
         return p;
      end
      len_in = root_floor(sq_in);
      len_out = root_floor(sq_out);
      p.shortened = (sq_in <= lim) || (sq_out <= lim);
      if (p.shortened) d = (len_in < len_out ? len_in : len_out) >> 1;
      else d = off;
      p.entry_x = tangent_coord(cx, dpx, d, len_in);
      p.entry_y = tangent_coord(cy, dpy, d, len_in);
      p.exit_x = tangent_coord(cx, dnx, d, len_out);
      p.exit_y = tangent_coord(cy, dny, d, len_out);
      return p;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %0d on %s: got %h expected %h", points_checked, what, got, want);
   endtask

   task automatic queue_corner(req_type c);
      pending_corners = {pending_corners, c};
   endtask

   // driver
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         expected_points = {expected_points, predict_tangents(req_data, offset_model)};
         corners_sent++;
      end
      if (!req_valid || !req_stall) begin
         if (pending_corners.size() > 0 && !reset &&
             (calm || $urandom_range(99) >= 20)) begin
            req_data <= pending_corners.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left > 1) || (!calm && $urandom_range(99) < 20);
   end

   // monitor
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report("unexpected item", 32'(rsp_data.entry_x), 32'h0);
         end else begin
            rsp_type w;
            w = expected_points.pop_front();
            if (rsp_data.entry_x !== w.entry_x)
               report("entry_x", 32'(rsp_data.entry_x), 32'(w.entry_x));
            if (rsp_data.entry_y !== w.entry_y)
               report("entry_y", 32'(rsp_data.entry_y), 32'(w.entry_y));
            if (rsp_data.exit_x !== w.exit_x)
               report("exit_x", 32'(rsp_data.exit_x), 32'(w.exit_x));
            if (rsp_data.exit_y !== w.exit_y)
               report("exit_y", 32'(rsp_data.exit_y), 32'(w.exit_y));
            if (rsp_data.shortened !== w.shortened)
               report("shortened", 32'(rsp_data.shortened), 32'(w.shortened));
            if (rsp_data.degenerate !== w.degenerate)
               report("degenerate", 32'(rsp_data.degenerate), 32'(w.degenerate));
            if (w.shortened) shortened_seen++;
            if (w.degenerate) degenerate_seen++;
         end
         points_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [COORD_W-1:0] clip(longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   function automatic req_type make_corner(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                           logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                           logic [COORD_W-1:0] nx, logic [COORD_W-1:0] ny);
      req_type c;
      c.prev_x = px; c.prev_y = py;
      c.corner_x = cx; c.corner_y = cy;
      c.next_x = nx; c.next_y = ny;
      return c;
   endfunction

   function automatic req_type random_corner(logic [OFFSET_W-1:0] off);
      req_type c;
      longint cx, cy, span, t;
      int kind;
      kind = $urandom_range(9);
      c = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      cx = c.corner_x;
      cy = c.corner_y;
      span = 4 * longint'(off) + 64;
      if (span > 2 * COORD_MAX) span = 2 * COORD_MAX;
      case (kind)
         4, 5, 6: begin
            c.prev_x = clip(cx + longint'($urandom_range(span)) - span / 2);
            c.prev_y = clip(cy + longint'($urandom_range(span)) - span / 2);
            c.next_x = clip(cx + longint'($urandom_range(span)) - span / 2);
            c.next_y = clip(cy + longint'($urandom_range(span)) - span / 2);
         end
         7: begin
            if ($urandom_range(1)) begin
               c.prev_x = c.corner_x; c.prev_y = c.corner_y;
            end else begin
               c.next_x = c.corner_x; c.next_y = c.corner_y;
            end
         end
         8: begin
            t = 2 * longint'(off) + longint'($urandom_range(2)) - 1;
            c.prev_x = clip(cx + ($urandom_range(1) ? t : -t));
            c.prev_y = c.corner_y;
            c.next_x = c.corner_x;
            c.next_y = clip(cy + ($urandom_range(1) ? t + 5 : -t - 5));
         end
         9: begin
            c.prev_x = $urandom_range(1) ? clip(COORD_MAX) : clip(COORD_MIN);
            c.next_y = $urandom_range(1) ? clip(COORD_MAX) : clip(COORD_MIN);
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_corners.size() != 0 || req_valid || expected_points.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == OFFSET_ADDR) offset_model = value[OFFSET_W-1:0];
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) queue_corner(random_corner(offset_model));
   endtask

   logic [COORD_W-1:0] hi_c, lo_c, o2;
   initial begin
      hi_c = clip(COORD_MAX);
      lo_c = clip(COORD_MIN);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners at reset offset
      o2 = 2 * 12800;
      queue_corner(make_corner(lo_c, lo_c, hi_c, hi_c, lo_c, hi_c));
      queue_corner(make_corner(hi_c, hi_c, lo_c, lo_c, hi_c, lo_c));
      queue_corner(make_corner(hi_c, lo_c, 0, 0, lo_c, hi_c));
      queue_corner(make_corner(5, 5, 5, 5, 900, 7));
      queue_corner(make_corner(900, 7, 5, 5, 5, 5));
      queue_corner(make_corner(lo_c, lo_c, lo_c, lo_c, lo_c, lo_c));
      queue_corner(make_corner(o2, 0, 0, 0, 0, o2));
      queue_corner(make_corner(o2 + 1, 0, 0, 0, 0, -(o2 + 1)));
      queue_corner(make_corner(-(o2 + 1), 0, 0, 0, 0, o2 + 1));
      queue_corner(make_corner(1, 0, 0, 0, 0, 1));
      queue_corner(make_corner(3, 1, 0, 0, -1, -3));
      queue_corner(make_corner(300000, 400000, 0, 0, -600000, 800000));
      queue_corner(make_corner(100, 0, 0, 0, 700000, 700000));
      queue_corner(make_corner(hi_c, hi_c, hi_c, lo_c, lo_c, lo_c));
      wait_idle();
      csr_write(UNUSED_ADDR, 32'h0000_0007);
      queue_corner(make_corner(o2 + 1, 0, 0, 0, 0, o2 + 1));
      random_phase(200);
      wait_idle();
      csr_write(OFFSET_ADDR, 32'h0);
      queue_corner(make_corner(1, 0, 0, 0, 0, 1));
      random_phase(200);
      wait_idle();
      csr_write(OFFSET_ADDR, 32'hFFFF_FFFF);
      queue_corner(make_corner(hi_c, hi_c, lo_c, lo_c, hi_c, lo_c));
      random_phase(200);
      wait_idle();
      csr_write(OFFSET_ADDR, 32'd3);
      calm = 1'b1;
      random_phase(200);
      wait_idle();
      calm = 1'b0;
      csr_write(OFFSET_ADDR, 32'd12800);
      random_phase(250);
      hold_go = 1'b1;
      wait_idle();
      for (int k = 0; k < 3; k++) begin
         csr_write(OFFSET_ADDR, $urandom_range(1 << (6 * k + 6)));
         random_phase(120);
         wait_idle();
      end
      $display("checked %0d of %0d corners over 8 offset settings", points_checked,
               corners_sent);
      $display("shortened %0d, zero-length leg %0d", shortened_seen, degenerate_seen);
      if (errors == 0 && expected_points.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/crtp_pkg.sv
design/corner_rounding_tangent_points_unit.sv
sim/testbench.sv
